### src/khhrt_pkg.sv
// ----------------------------------------------------------------------------
// khhrt_pkg
// Shared types, codes and reset values of the key hit / hold / repeat tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package khhrt_pkg;

	localparam int NUM_KEYS_DEF  = 8;
	localparam int TICK_BITS_DEF = 32;
	localparam int KEY_SLOTS     = 8;
	localparam int COMBO_DEPTH   = 256;
	localparam int COMBO_W       = 8;
	localparam int CFG_IDX_W     = 3;
	localparam int CFG_DATA_W    = 16;

	// Command kinds.
	localparam logic [2:0] KIND_TICK   = 3'd0;
	localparam logic [2:0] KIND_KEY    = 3'd1;
	localparam logic [2:0] KIND_ALL    = 3'd2;
	localparam logic [2:0] KIND_ANY    = 3'd3;
	localparam logic [2:0] KIND_PEEK   = 3'd4;
	localparam logic [2:0] KIND_REPEAT = 3'd5;

	// Reported key states.
	localparam logic [1:0] ST_RELEASED = 2'd0;
	localparam logic [1:0] ST_HIT      = 2'd1;
	localparam logic [1:0] ST_PRESSED  = 2'd2;
	localparam logic [1:0] ST_HOLDING  = 2'd3;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_LOCKED  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PRESS   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HOLD    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_REPEAT  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SPEEDUP = 3'd4;

	localparam logic [CFG_DATA_W-1:0] PRESS_TICKS_RST   = 16'd16;
	localparam logic [CFG_DATA_W-1:0] HOLD_TICKS_RST    = 16'd1000;
	localparam logic [CFG_DATA_W-1:0] REPEAT_TICKS_RST  = 16'd500;
	localparam logic [CFG_DATA_W-1:0] SPEEDUP_TICKS_RST = 16'd3000;

	typedef struct packed {
		logic [2:0] kind;
		logic [2:0] key_index;
		logic       key_down;
		logic [7:0] key_mask;
	} key_cmd_t;

	typedef struct packed {
		logic [1:0] key_state;
		logic       beep_request;
	} key_result_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_WALK,
		S_DRAIN,
		S_DONE
	} seq_state_t;

endpackage

`default_nettype wire

### src/key_hit_hold_repeat_tracker_top.sv
// ----------------------------------------------------------------------------
// key_hit_hold_repeat_tracker_top
// Keypad tracker: press stamps and a seen-mark per key combination, classified
// into released, hit, pressed or holding, with single-key auto-repeat.
// ----------------------------------------------------------------------------
// Tick and key-change words give no result.
// A query that fails the key-down or lock check reports on done the cycle after
// it is taken. Any other query walks the stamp memory one entry per cycle, with
// busy high through the WALK, DRAIN and DONE states; done rises as busy falls.
// After reset the seen-mark memory is cleared one entry per cycle, all 256
// entries, with busy high. The receiver cannot stall; done lasts exactly one cycle.
`default_nettype none

module key_hit_hold_repeat_tracker_top #(
	parameter int NUM_KEYS  = khhrt_pkg::NUM_KEYS_DEF,
	parameter int TICK_BITS = khhrt_pkg::TICK_BITS_DEF
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   start,
	output logic                                  busy,
	input  wire  khhrt_pkg::key_cmd_t             cmd,
	output logic                                  done,
	output khhrt_pkg::key_result_t                result,
	input  wire                                   cfg_we,
	input  wire  [khhrt_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire  [khhrt_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

	localparam int KEYS_USED = (NUM_KEYS < khhrt_pkg::KEY_SLOTS) ? NUM_KEYS
		: khhrt_pkg::KEY_SLOTS;
	localparam int KIDX_W = (KEYS_USED > 1) ? $clog2(KEYS_USED) : 1;
	localparam logic [KIDX_W-1:0] LAST_IDX = KIDX_W'(KEYS_USED - 1);
	localparam int CW = khhrt_pkg::COMBO_W;
	localparam logic [CW-1:0] CLR_LAST = CW'(khhrt_pkg::COMBO_DEPTH - 1);

	// Configuration registers.
	logic                             locked_q;
	logic [khhrt_pkg::CFG_DATA_W-1:0] press_ticks_q;
	logic [khhrt_pkg::CFG_DATA_W-1:0] hold_ticks_q;
	logic [khhrt_pkg::CFG_DATA_W-1:0] repeat_ticks_q;
	logic [khhrt_pkg::CFG_DATA_W-1:0] speedup_ticks_q;

	// Tracker state.
	logic [TICK_BITS-1:0]  tick_q;
	logic [CW-1:0]         keys_down_q;
	logic [KEYS_USED-1:0]  stamp_vld_q;
	logic [2*TICK_BITS-1:0] stamp_mem [KEYS_USED];
	logic                  seen_mem [khhrt_pkg::COMBO_DEPTH];

	khhrt_pkg::seq_state_t state_q, state_d;

	// Sequencer registers.
	logic [CW-1:0]         clr_q;
	logic [KIDX_W-1:0]     idx_q;
	logic [CW-1:0]         combo_q;
	logic [2:0]            kind_q;
	logic [KIDX_W-1:0]     key_q;
	logic                  proc_v_s1;
	logic [KIDX_W-1:0]     proc_idx_s1;
	logic [2*TICK_BITS-1:0] stamp_rd_s1;
	logic                  seen_rd_q;
	logic                  any_q;
	logic [TICK_BITS-1:0]  min_age_q;
	logic [TICK_BITS-1:0]  rep_age_q;
	logic [TICK_BITS-1:0]  sel_press_q;
	logic                  done_q;
	khhrt_pkg::key_result_t result_q;

	// Accept decode.
	logic          acc;
	logic          key_ok;
	logic [CW-1:0] valid_keys;
	logic [CW-1:0] mask_v;
	logic [CW-1:0] key_bit;
	logic [CW-1:0] combo_d;
	logic          is_query;
	logic          early;
	logic          walk_start;
	logic          key_rise;

	// Memory ports.
	logic                   stamp_re;
	logic                   stamp_we;
	logic [KIDX_W-1:0]      stamp_wa;
	logic [2*TICK_BITS-1:0] stamp_wd;
	logic                   seen_re;
	logic                   seen_we;
	logic [CW-1:0]          seen_wa;
	logic                   seen_wd;

	// Walk datapath.
	logic [2*TICK_BITS-1:0] stamp_data;
	logic [TICK_BITS-1:0]   press_s1;
	logic [TICK_BITS-1:0]   age_p;
	logic [TICK_BITS-1:0]   age_r;
	logic [KEYS_USED-1:0]   sel_vec;
	logic                   take;

	// Final classification.
	logic [TICK_BITS-1:0]   age;
	logic                   is_released;
	logic                   in_hold;
	logic [1:0]             base_state;
	logic [TICK_BITS-1:0]   delay;
	logic                   restamp;
	logic                   mark_set;
	khhrt_pkg::key_result_t final_res;

	always_comb begin
		for (int i = 0; i < CW; i++) begin
			valid_keys[i] = (i < NUM_KEYS);
		end
	end

	assign acc      = start && !busy;
	assign key_ok   = (32'(cmd.key_index) < NUM_KEYS);
	assign mask_v   = cmd.key_mask & valid_keys;
	assign key_bit  = CW'(1) << cmd.key_index;
	assign key_rise = (cmd.kind == khhrt_pkg::KIND_KEY) && key_ok && cmd.key_down
		&& ((keys_down_q & key_bit) == '0);

	always_comb begin
		combo_d  = '0;
		is_query = 1'b0;
		early    = 1'b0;
		case (cmd.kind)
			khhrt_pkg::KIND_ALL: begin
				is_query = 1'b1;
				combo_d  = mask_v;
				early    = ((keys_down_q & mask_v) != mask_v) || locked_q;
			end
			khhrt_pkg::KIND_ANY, khhrt_pkg::KIND_PEEK: begin
				is_query = 1'b1;
				combo_d  = keys_down_q & mask_v;
				early    = ((keys_down_q & mask_v) == '0) || locked_q;
			end
			khhrt_pkg::KIND_REPEAT: begin
				is_query = 1'b1;
				combo_d  = key_bit;
				early    = !key_ok || ((keys_down_q & key_bit) == '0) || locked_q;
			end
			default: begin
				is_query = 1'b0;
			end
		endcase
	end

	assign walk_start = acc && is_query && !early;

	// Walk: read data of entry proc_idx_s1 arrives in the cycle after its read.
	assign stamp_data = stamp_vld_q[proc_idx_s1] ? stamp_rd_s1 : '0;
	assign press_s1   = stamp_data[TICK_BITS-1:0];
	assign age_p      = tick_q - press_s1;
	assign age_r      = tick_q - stamp_data[2*TICK_BITS-1:TICK_BITS];
	assign sel_vec    = combo_q[KEYS_USED-1:0];
	assign take       = proc_v_s1 && sel_vec[proc_idx_s1];

	// An empty selection counts as one stamp of zero, whose age is the tick itself.
	assign age         = any_q ? min_age_q : tick_q;
	assign is_released = age < TICK_BITS'(press_ticks_q);
	assign in_hold     = age < TICK_BITS'(hold_ticks_q);
	assign delay       = (min_age_q >= TICK_BITS'(speedup_ticks_q))
		? TICK_BITS'(repeat_ticks_q >> 1) : TICK_BITS'(repeat_ticks_q);

	always_comb begin
		if (is_released) begin
			base_state = khhrt_pkg::ST_RELEASED;
		end else if (in_hold) begin
			base_state = seen_rd_q ? khhrt_pkg::ST_PRESSED : khhrt_pkg::ST_HIT;
		end else begin
			base_state = khhrt_pkg::ST_HOLDING;
		end
		mark_set = (base_state == khhrt_pkg::ST_HIT) && (kind_q != khhrt_pkg::KIND_PEEK);
		restamp  = 1'b0;
		final_res.beep_request = mark_set;
		final_res.key_state    = base_state;
		if (kind_q == khhrt_pkg::KIND_REPEAT) begin
			case (base_state)
				khhrt_pkg::ST_HIT: begin
					final_res.key_state = khhrt_pkg::ST_HIT;
				end
				khhrt_pkg::ST_HOLDING: begin
					restamp = (rep_age_q >= delay);
					final_res.key_state = restamp ? khhrt_pkg::ST_HIT
						: khhrt_pkg::ST_RELEASED;
				end
				default: begin
					final_res.key_state = khhrt_pkg::ST_RELEASED;
				end
			endcase
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			khhrt_pkg::S_CLEAR: begin
				if (clr_q == CLR_LAST) state_d = khhrt_pkg::S_IDLE;
			end
			khhrt_pkg::S_IDLE: begin
				if (walk_start) state_d = khhrt_pkg::S_WALK;
			end
			khhrt_pkg::S_WALK: begin
				if (idx_q == LAST_IDX) state_d = khhrt_pkg::S_DRAIN;
			end
			khhrt_pkg::S_DRAIN: begin
				state_d = khhrt_pkg::S_DONE;
			end
			khhrt_pkg::S_DONE: begin
				state_d = khhrt_pkg::S_IDLE;
			end
			default: begin
				state_d = khhrt_pkg::S_IDLE;
			end
		endcase
	end

	// Outputs of the sequencer: memory ports and busy.
	always_comb begin
		busy     = (state_q != khhrt_pkg::S_IDLE);
		stamp_re = (state_q == khhrt_pkg::S_WALK);
		stamp_we = 1'b0;
		stamp_wa = key_q;
		stamp_wd = {tick_q, sel_press_q};
		seen_re  = walk_start;
		seen_we  = 1'b0;
		seen_wa  = combo_q;
		seen_wd  = 1'b0;
		case (state_q)
			khhrt_pkg::S_CLEAR: begin
				seen_we = 1'b1;
				seen_wa = clr_q;
			end
			khhrt_pkg::S_IDLE: begin
				stamp_we = acc && key_rise;
				stamp_wa = cmd.key_index[KIDX_W-1:0];
				stamp_wd = {tick_q, tick_q};
			end
			khhrt_pkg::S_DONE: begin
				stamp_we = restamp;
				seen_we  = is_released || mark_set;
				seen_wd  = mark_set;
			end
			default: begin
				stamp_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (stamp_we) stamp_mem[stamp_wa] <= stamp_wd;
		if (stamp_re) stamp_rd_s1 <= stamp_mem[idx_q];
	end

	always_ff @(posedge clk) begin
		if (seen_we) seen_mem[seen_wa] <= seen_wd;
		if (seen_re) seen_rd_q <= seen_mem[combo_d];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			locked_q        <= 1'b0;
			press_ticks_q   <= khhrt_pkg::PRESS_TICKS_RST;
			hold_ticks_q    <= khhrt_pkg::HOLD_TICKS_RST;
			repeat_ticks_q  <= khhrt_pkg::REPEAT_TICKS_RST;
			speedup_ticks_q <= khhrt_pkg::SPEEDUP_TICKS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				khhrt_pkg::CFG_LOCKED:  locked_q        <= cfg_wdata[0];
				khhrt_pkg::CFG_PRESS:   press_ticks_q   <= cfg_wdata;
				khhrt_pkg::CFG_HOLD:    hold_ticks_q    <= cfg_wdata;
				khhrt_pkg::CFG_REPEAT:  repeat_ticks_q  <= cfg_wdata;
				khhrt_pkg::CFG_SPEEDUP: speedup_ticks_q <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= khhrt_pkg::S_CLEAR;
			clr_q       <= '0;
			idx_q       <= '0;
			tick_q      <= '0;
			keys_down_q <= '0;
			stamp_vld_q <= '0;
			proc_v_s1   <= 1'b0;
			proc_idx_s1 <= '0;
			any_q       <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			state_q     <= state_d;
			proc_v_s1   <= stamp_re;
			proc_idx_s1 <= idx_q;
			done_q      <= 1'b0;
			if (state_q == khhrt_pkg::S_CLEAR) clr_q <= clr_q + 1'b1;
			if (state_q == khhrt_pkg::S_WALK) idx_q <= idx_q + 1'b1;
			if (stamp_we) stamp_vld_q[stamp_wa] <= 1'b1;
			if (acc && cmd.kind == khhrt_pkg::KIND_TICK) tick_q <= tick_q + 1'b1;
			if (acc && cmd.kind == khhrt_pkg::KIND_KEY && key_ok) begin
				if (cmd.key_down) keys_down_q <= keys_down_q | key_bit;
				else keys_down_q <= keys_down_q & ~key_bit;
			end
			if (walk_start) begin
				idx_q <= '0;
				any_q <= 1'b0;
			end
			if (take) any_q <= 1'b1;
			if (acc && is_query && early) done_q <= 1'b1;
			if (state_q == khhrt_pkg::S_DONE) done_q <= 1'b1;
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (walk_start) begin
			combo_q <= combo_d;
			kind_q  <= cmd.kind;
			key_q   <= cmd.key_index[KIDX_W-1:0];
		end
		if (take && (!any_q || age_p < min_age_q)) min_age_q <= age_p;
		if (take) begin
			rep_age_q   <= age_r;
			sel_press_q <= press_s1;
		end
		if (acc && is_query && early) begin
			result_q.key_state    <= khhrt_pkg::ST_RELEASED;
			result_q.beep_request <= 1'b0;
		end else if (state_q == khhrt_pkg::S_DONE) begin
			result_q <= final_res;
		end
	end

	assign done   = done_q;
	assign result = result_q;

	// A result follows either a query refused at the door or a finished walk.
	a_done_source: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(start && !busy) || $past(state_q == khhrt_pkg::S_DONE)))
		else $error("result without a query behind it");

	// Beep only goes with a reported hit.
	a_beep_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.beep_request) |-> (result.key_state == khhrt_pkg::ST_HIT))
		else $error("beep without hit");

	// The repeat stamp is rewritten only at the end of a repeat query.
	a_restamp_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(stamp_we && state_q == khhrt_pkg::S_DONE) |-> (kind_q == khhrt_pkg::KIND_REPEAT))
		else $error("restamp on a non-repeat query");

	// Walk data is only taken in the cycle after a read was issued.
	a_walk_read: assert property (@(posedge clk) disable iff (!arst_n)
		proc_v_s1 |-> $past(state_q == khhrt_pkg::S_WALK))
		else $error("walk data without a read");

endmodule

`default_nettype wire
